/* design/skts_pkg.sv */
// Package of the soft-knee tanh saturator: widths, fixed-point constants,
// the stage word types that pass between modules and the tanh table.
// No dependencies.
`default_nettype none

package skts_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int MAG_W    = 19;
  localparam int OVER_W   = 17;
  localparam int TH_W     = 16;
  localparam int FRAC_W   = 17;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
  localparam logic [14:0]         KNEE       = 15'd22938;
  localparam logic [13:0]         SPAN       = 14'd9830;
  localparam logic [MAG_W-1:0]    KNEE_M     = 19'd22938;
  localparam logic [MAG_W-1:0]    EXCESS_LIM = 19'd39320;
  localparam logic [SAMPLE_W-1:0] SAT_MAX    = 16'd32767;

  // Shift-and-subtract quotient, used only to build constants.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Division of the excess by the span: over = (d * 16384) / 4915.
  localparam int unsigned DivDen = 4915;
  localparam logic [12:0] DIV_DEN_C = 13'd4915;
  localparam logic [21:0] RECIP = 22'(udiv64(64'd1 << 34, 64'(DivDen)));

  localparam int TANH_DEPTH_LOG2 = 8;
  localparam int TANH_DEPTH      = 1 << TANH_DEPTH_LOG2;

  typedef logic [TANH_DEPTH:0][TH_W-1:0] tanh_tab_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] m;
  } gain_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              pass;
    logic              sat;
    logic [14:0]       low;
    logic [OVER_W-1:0] over;
  } excess_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            pass;
    logic            sat;
    logic [14:0]     low;
    logic [TH_W-1:0] th;
  } shape_t;

  // Entry i holds tanh(4i/D) in Q.15, built from exp(-8/D) in Q.30.
  function automatic tanh_tab_t build_tanh_tab();
    longint unsigned one_q30;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    longint unsigned num;
    tanh_tab_t       tab;
    one_q30 = 64'd1 << 30;
    sum  = one_q30;
    term = one_q30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(term * 64'd8, 64'(TANH_DEPTH) * 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = one_q30;
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      den    = one_q30 + e;
      num    = ((one_q30 - e) << 15) + (den >> 1);
      tab[i] = TH_W'(udiv64(num, den));
      e      = (e * sum + (one_q30 >> 1)) >> 30;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

`default_nettype wire

/* design/skts_if.sv */
// Stream interfaces of the saturator: one for input words, one for results.
// Depends on nothing.
`default_nettype none

interface skts_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface skts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* design/skts_gain.sv */
// Gain stage: magnitude of the input sample times the drive gain, rounded.
// Depends on skts_pkg.
`default_nettype none

module skts_gain (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [skts_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [skts_pkg::GAIN_W-1:0]    gain,
  output skts_pkg::gain_t                     st_out
);
  import skts_pkg::*;

  gain_t       st_r;
  gain_t       st_nxt;
  logic [16:0] mag_in;
  logic [31:0] prod;

  always_comb begin
    mag_in       = sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
    prod         = 32'(mag_in) * 32'(gain) + 32'd2048;
    st_nxt.valid = in_valid;
    st_nxt.neg   = sample[SAMPLE_W-1];
    st_nxt.m     = prod[30:12];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.neg <= st_nxt.neg;
      st_r.m   <= st_nxt.m;
    end
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  assign st_out = st_r;

endmodule

`default_nettype wire

/* design/skts_excess.sv */
// Excess stages: knee test, then the excess over the knee divided by the
// span by reciprocal multiply and a one-step correction. Depends on skts_pkg.
`default_nettype none

module skts_excess (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire skts_pkg::gain_t  st_in,
  output skts_pkg::excess_t     st_out
);
  import skts_pkg::*;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              pass;
    logic              sat;
    logic [14:0]       low;
    logic [15:0]       d;
    logic [OVER_W-1:0] q0;
  } quot_t;

  quot_t       qa_r;
  quot_t       qa_nxt;
  excess_t     st_r;
  excess_t     st_nxt;
  logic [MAG_W-1:0] d_full;
  logic [37:0] qprod;
  logic [29:0] back;
  logic [29:0] rem;

  always_comb begin
    d_full       = st_in.m - KNEE_M;
    qprod        = 38'(d_full[15:0]) * 38'(RECIP);
    qa_nxt.valid = st_in.valid;
    qa_nxt.neg   = st_in.neg;
    qa_nxt.pass  = (st_in.m <= KNEE_M);
    qa_nxt.sat   = (st_in.m > KNEE_M) && (d_full >= EXCESS_LIM);
    qa_nxt.low   = st_in.m[14:0];
    qa_nxt.d     = d_full[15:0];
    qa_nxt.q0    = qprod[36:20];
  end

  always_comb begin
    back         = 30'(qa_r.q0) * 30'(DIV_DEN_C);
    rem          = {qa_r.d, 14'd0} - back;
    st_nxt.valid = qa_r.valid;
    st_nxt.neg   = qa_r.neg;
    st_nxt.pass  = qa_r.pass;
    st_nxt.sat   = qa_r.sat;
    st_nxt.low   = qa_r.low;
    st_nxt.over  = (rem >= 30'(DIV_DEN_C)) ? (qa_r.q0 + 17'd1) : qa_r.q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r.neg  <= qa_nxt.neg;
      qa_r.pass <= qa_nxt.pass;
      qa_r.sat  <= qa_nxt.sat;
      qa_r.low  <= qa_nxt.low;
      qa_r.d    <= qa_nxt.d;
      qa_r.q0   <= qa_nxt.q0;
      st_r.neg  <= st_nxt.neg;
      st_r.pass <= st_nxt.pass;
      st_r.sat  <= st_nxt.sat;
      st_r.low  <= st_nxt.low;
      st_r.over <= st_nxt.over;
    end
    if (!rst_n) begin
      qa_r.valid <= 1'b0;
      st_r.valid <= 1'b0;
    end else if (en) begin
      qa_r.valid <= qa_nxt.valid;
      st_r.valid <= st_nxt.valid;
    end
  end

  assign st_out = st_r;

endmodule

`default_nettype wire

/* design/skts_tanh.sv */
// Tanh stages: table lookup of two neighboring entries, then linear
// interpolation in Q.15. Depends on skts_pkg and its constant table.
`default_nettype none

module skts_tanh (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire skts_pkg::excess_t st_in,
  output skts_pkg::shape_t       st_out
);
  import skts_pkg::*;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              pass;
    logic              sat;
    logic [14:0]       low;
    logic [TH_W-1:0]   t_lo;
    logic [TH_W-1:0]   t_hi;
    logic [FRAC_W-1:0] f;
  } look_t;

  look_t                      lk_r;
  look_t                      lk_nxt;
  shape_t                     st_r;
  shape_t                     st_nxt;
  logic [TANH_DEPTH_LOG2-1:0] idx;
  logic [TANH_DEPTH_LOG2:0]   idx_hi;
  logic [33:0]                acc;

  always_comb begin
    idx          = st_in.over[OVER_W-1 -: TANH_DEPTH_LOG2];
    idx_hi       = {1'b0, idx} + 1'b1;
    lk_nxt.valid = st_in.valid;
    lk_nxt.neg   = st_in.neg;
    lk_nxt.pass  = st_in.pass;
    lk_nxt.sat   = st_in.sat;
    lk_nxt.low   = st_in.low;
    lk_nxt.t_lo  = TANH_TAB[idx];
    lk_nxt.t_hi  = TANH_TAB[idx_hi];
    lk_nxt.f     = {st_in.over[OVER_W-TANH_DEPTH_LOG2-1:0], TANH_DEPTH_LOG2'(0)};
  end

  always_comb begin
    acc = 34'(lk_r.t_lo) * (34'(1) << FRAC_W) - 34'(lk_r.t_lo) * 34'(lk_r.f)
        + 34'(lk_r.t_hi) * 34'(lk_r.f) + 34'd65536;
    st_nxt.valid = lk_r.valid;
    st_nxt.neg   = lk_r.neg;
    st_nxt.pass  = lk_r.pass;
    st_nxt.sat   = lk_r.sat;
    st_nxt.low   = lk_r.low;
    st_nxt.th    = acc[FRAC_W +: TH_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lk_r.neg  <= lk_nxt.neg;
      lk_r.pass <= lk_nxt.pass;
      lk_r.sat  <= lk_nxt.sat;
      lk_r.low  <= lk_nxt.low;
      lk_r.t_lo <= lk_nxt.t_lo;
      lk_r.t_hi <= lk_nxt.t_hi;
      lk_r.f    <= lk_nxt.f;
      st_r.neg  <= st_nxt.neg;
      st_r.pass <= st_nxt.pass;
      st_r.sat  <= st_nxt.sat;
      st_r.low  <= st_nxt.low;
      st_r.th   <= st_nxt.th;
    end
    if (!rst_n) begin
      lk_r.valid <= 1'b0;
      st_r.valid <= 1'b0;
    end else if (en) begin
      lk_r.valid <= lk_nxt.valid;
      st_r.valid <= st_nxt.valid;
    end
  end

  assign st_out = st_r;

endmodule

`default_nettype wire

/* design/skts_out.sv */
// Output stage: knee plus scaled tanh, saturation and sign, into the
// result register. Depends on skts_pkg.
`default_nettype none

module skts_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire skts_pkg::shape_t              st_in,
  output logic                               out_valid,
  output logic [skts_pkg::SAMPLE_W-1:0]      out_sample
);
  import skts_pkg::*;

  logic                valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] sample_nxt;
  logic [29:0]         scaled;
  logic [SAMPLE_W-1:0] shaped;
  logic [SAMPLE_W-1:0] mag;

  always_comb begin
    scaled = 30'(SPAN) * 30'(st_in.th) + 30'd16384;
    shaped = 16'(KNEE) + 16'(scaled[29:15]);
    priority if (st_in.sat) begin
      mag = SAT_MAX;
    end else if (st_in.pass) begin
      mag = {1'b0, st_in.low};
    end else if (shaped > SAT_MAX) begin
      mag = SAT_MAX;
    end else begin
      mag = shaped;
    end
    sample_nxt = st_in.neg ? (16'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= st_in.valid;
    end
  end

  assign out_valid  = valid_r;
  assign out_sample = sample_r;

endmodule

`default_nettype wire

/* design/soft_knee_tanh_saturator.sv */
// Top level of the soft-knee tanh saturator: drive gain register and the
// six-stage pipeline. Depends on skts_pkg, skts_if and the skts_ stage modules.
//
// Usage:
//   in_ch carries one signed Q1.15 sample per word; out_ch returns one
//   soft-limited Q1.15 sample per word, in order, one result per input.
//   cfg_we/cfg_wdata write the Q4.12 drive gain; write it only while the
//   pipeline holds no words.
// Path: a word accepted on in_ch is registered in each stage in turn and is
//   then shown on out_ch from the output shaping register.
// Throughput: one word per cycle unless out_ch stalls; the pipeline is six
//   register stages deep (gain multiply, knee test and reciprocal multiply,
//   division correction, table lookup, interpolation, output shaping).
// Stall: when the receiver holds out_ch.ready low with a result waiting,
//   the whole pipeline freezes and in_ch.ready drops; no word is lost or
//   repeated, and no new word enters until the waiting result is taken.
// Reset: rst_n low at a clock edge clears all valid bits and sets the gain
//   to unity (4096).
`default_nettype none

module soft_knee_tanh_saturator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  skts_in_if.sink                           in_ch,
  skts_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [skts_pkg::GAIN_W-1:0]  cfg_wdata
);
  import skts_pkg::*;

  logic [GAIN_W-1:0]   gain_r;
  logic                en;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_sample;
  gain_t               gain_st;
  excess_t             excess_st;
  shape_t              shape_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  assign en           = out_ch.ready || !out_valid;
  assign in_ch.ready  = en;

  skts_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .sample   (in_ch.sample_in),
    .gain     (gain_r),
    .st_out   (gain_st)
  );

  skts_excess u_excess (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .st_in  (gain_st),
    .st_out (excess_st)
  );

  skts_tanh u_tanh (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .st_in  (excess_st),
    .st_out (shape_st)
  );

  skts_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .st_in      (shape_st),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for soft_knee_tanh_saturator: random and directed sample words under
// several drive gains, checked in order against a fixed-point tanh knee predictor.
// Depends on skts_pkg, skts_if and the saturator RTL.
`timescale 1ns / 1ps

module tb;

  localparam int KNEE_Q15    = 22938;
  localparam int SPAN_Q15    = 9830;
  localparam int LUT_DEPTH   = 256;
  localparam int STALL_LIMIT = 1000;

  class sat_scoreboard;
    bit [15:0]          tanh_lut [LUT_DEPTH+1];
    logic signed [15:0] expected_out [$];
    bit [15:0]          gain;
    int                 errors;

    function new();
      longint unsigned one;
      longint unsigned decay;
      longint unsigned term;
      longint unsigned e;
      longint unsigned den;
      longint unsigned num;
      one   = 64'd1 << 30;
      decay = one;
      term  = one;
      for (int k = 1; k <= 24; k++) begin
        term = (term * 64'd8) / (64'(LUT_DEPTH) * 64'(k));
        if ((k % 2) == 1) begin
          decay = decay - term;
        end else begin
          decay = decay + term;
        end
      end
      e = one;
      for (int i = 0; i <= LUT_DEPTH; i++) begin
        den         = one + e;
        num         = ((one - e) << 15) + (den >> 1);
        tanh_lut[i] = 16'(num / den);
        e           = (e * decay + (one >> 1)) >> 30;
      end
      gain   = 16'd4096;
      errors = 0;
    endfunction

    function longint unsigned tanh_of(longint unsigned over);
      longint unsigned p;
      longint unsigned idx;
      longint unsigned frac;
      if (over >= (64'd4 << 15)) begin
        return 64'd32768;
      end
      p    = over * 64'(LUT_DEPTH);
      idx  = p >> 17;
      frac = p & 64'h1FFFF;
      if (idx >= 64'(LUT_DEPTH)) begin
        return 64'd32768;
      end
      return (64'(tanh_lut[idx]) * ((64'd1 << 17) - frac) +
              64'(tanh_lut[idx + 1]) * frac + (64'd1 << 16)) >> 17;
    endfunction

    function logic signed [15:0] clip_sample(logic signed [15:0] s);
      bit [15:0]       raw;
      longint unsigned mag_in;
      longint unsigned m;
      longint unsigned over;
      longint unsigned mag;
      raw    = s;
      mag_in = 64'(raw);
      if (raw[15]) begin
        mag_in = 64'h10000 - mag_in;
      end
      m = (mag_in * 64'(gain) + 64'd2048) >> 12;
      if (m <= 64'(KNEE_Q15)) begin
        mag = m;
      end else begin
        over = ((m - 64'(KNEE_Q15)) << 15) / 64'(SPAN_Q15);
        mag  = 64'(KNEE_Q15) + ((64'(SPAN_Q15) * tanh_of(over) + 64'd16384) >> 15);
      end
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      if (raw[15]) begin
        return 16'(64'h10000 - mag);
      end else begin
        return 16'(mag);
      end
    endfunction

    function void note_word(logic signed [15:0] s);
      expected_out.push_back(clip_sample(s));
    endfunction

    function void check_word(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output word: sample_out %0d", got);
        end
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("sample_out mismatch: expected %0d, got %0d", want, got);
          end
        end
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [skts_pkg::GAIN_W-1:0] cfg_wdata;

  skts_in_if  in_ch ();
  skts_out_if out_ch ();

  soft_knee_tanh_saturator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sat_scoreboard      sb;
  bit                 idle_en = 1'b1;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;
  logic signed [15:0] unity_words [12];
  logic signed [15:0] hot_words [7];
  logic signed [15:0] zero_words [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_word(in_ch.sample_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_word(out_ch.sample_out);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[soft_knee_tanh_saturator] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = 1'b1;
      if (idle_en && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 18);
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    int                 target;
    logic signed [15:0] s;
    case ($urandom_range(0, 3))
      0, 1: s = 16'($urandom);
      2: begin
        if (sb.gain == 16'd0) begin
          s = 16'($urandom);
        end else begin
          target = (KNEE_Q15 * 4096) / int'(sb.gain) + int'($urandom_range(0, 64)) - 32;
          if (target > 32767 || target < 0) begin
            s = 16'($urandom);
          end else begin
            s = $urandom_range(0, 1) ? 16'(-target) : 16'(target);
          end
        end
      end
      default: begin
        s = $urandom_range(0, 1) ? 16'(-32768 + int'($urandom_range(0, 15)))
                                 : 16'(32767 - int'($urandom_range(0, 15)));
      end
    endcase
    return s;
  endfunction

  task automatic send_word(input logic signed [15:0] s);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(rand_sample());
    end
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_gain(input logic [skts_pkg::GAIN_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.gain   = value;
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = 16'sd0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    unity_words = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, 16'sh8000, 16'sd22938,
                    -16'sd22938, 16'sd22939, -16'sd22939, 16'sd16384, 16'sd21845,
                    16'shAAAA};
    hot_words   = '{16'sd1, -16'sd1, 16'sd1433, -16'sd1434, 16'sd3900, -16'sd3900,
                    16'sd32767};
    zero_words  = '{16'sd32767, 16'sh8000, 16'sd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (unity_words[i]) send_word(unity_words[i]);
    run_random(250);

    settle();
    write_gain(16'hFFFF);
    foreach (hot_words[i]) send_word(hot_words[i]);
    run_random(200);

    settle();
    write_gain(16'h0000);
    foreach (zero_words[i]) send_word(zero_words[i]);
    run_random(100);

    settle();
    write_gain(16'd1);
    run_random(150);

    settle();
    write_gain(16'd8192);
    run_random(125);
    settle();
    run_random(125);

    repeat (3) begin
      settle();
      write_gain(16'($urandom_range(4096, 20000)));
      run_random(250);
    end

    settle();
    write_gain(16'($urandom));
    run_random(200);

    settle();
    idle_en = 1'b0;
    write_gain(16'd4096);
    run_random(300);

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[soft_knee_tanh_saturator] OK");
    end else begin
      $display("[soft_knee_tanh_saturator] ERROR");
    end
    $finish;
  end

endmodule
